// File: rtl/biquad_iir_with_output_clamp_core_macros.svh
`ifndef BIQUAD_IIR_WITH_OUTPUT_CLAMP_CORE_MACROS_SVH
`define BIQUAD_IIR_WITH_OUTPUT_CLAMP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BIQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BIQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad assertion failed");

`endif

// File: rtl/biquad_pkg.sv
package biquad_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int COEF_WIDTH     = 24;
    localparam int LIMIT_WIDTH    = 24;
    // output history must hold a full limit value as well as a sample
    localparam int HIST_WIDTH     = (SAMPLE_WIDTH > LIMIT_WIDTH) ? SAMPLE_WIDTH : LIMIT_WIDTH;
    localparam int PROD_WIDTH     = COEF_WIDTH + HIST_WIDTH;
    localparam int ACC_WIDTH      = PROD_WIDTH + 4;

    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int REG_IDX_WIDTH  = 3;

    localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_B0      = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_B1      = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_B2      = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_A1      = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_COEF_A2      = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_LIMIT_LOW    = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] REG_LIMIT_HIGH   = 3'd6;
    localparam logic [REG_IDX_WIDTH-1:0] REG_CLAMP_ENABLE = 3'd7;

    localparam logic signed [LIMIT_WIDTH-1:0] LIMIT_LOW_RESET  =
        {1'b1, {(LIMIT_WIDTH-1){1'b0}}};
    localparam logic signed [LIMIT_WIDTH-1:0] LIMIT_HIGH_RESET =
        {1'b0, {(LIMIT_WIDTH-1){1'b1}}};

    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic                           req_type;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           limited;
    } out_item_t;

endpackage

// File: rtl/biquad_iir_with_output_clamp_core.sv
// Direct-form-I biquad with rounding, saturation and optional anti-windup
// clamp. One request (filter a sample or clear the history) is taken per
// clock while in_stall is low and gives exactly one result: the request
// is registered, then the five parallel 24-bit multiplies, sum, round,
// saturate and clamp run as it moves into the result register, and the
// history updates at that same edge; the sustained rate is one sample per
// clock while out_stall is low. A result waiting under out_stall does not
// block one more request from entering the input register. Coefficients
// are signed Q4.20; the APB registers sit at byte address 4*index and
// should be written only while no request is pending.
`include "biquad_iir_with_output_clamp_core_macros.svh"

module biquad_iir_with_output_clamp_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  biquad_pkg::in_item_t                  in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output biquad_pkg::out_item_t                 out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [biquad_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [biquad_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [biquad_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                  pready
);

    localparam int SW = biquad_pkg::SAMPLE_WIDTH;
    localparam int CW = biquad_pkg::COEF_WIDTH;
    localparam int LW = biquad_pkg::LIMIT_WIDTH;
    localparam int HW = biquad_pkg::HIST_WIDTH;
    localparam int PW = biquad_pkg::PROD_WIDTH;
    localparam int AW = biquad_pkg::ACC_WIDTH;
    localparam int FB = biquad_pkg::COEF_FRAC_BITS;
    localparam int DW = biquad_pkg::APB_DATA_WIDTH;

    localparam logic signed [AW-1:0] ROUND_BIAS = AW'(1) <<< (FB - 1);
    localparam logic signed [AW-1:0] SAT_MAX    = AW'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [AW-1:0] SAT_MIN    = -SAT_MAX - AW'(1);

    // configuration
    logic signed [CW-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg, coef_a1_reg, coef_a2_reg;
    logic signed [LW-1:0] limit_low_reg, limit_high_reg;
    logic                 clamp_enable_reg;
    logic                           cfg_write;
    logic [biquad_pkg::REG_IDX_WIDTH-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[biquad_pkg::APB_ADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg      <= '0;
            coef_b1_reg      <= '0;
            coef_b2_reg      <= '0;
            coef_a1_reg      <= '0;
            coef_a2_reg      <= '0;
            limit_low_reg    <= biquad_pkg::LIMIT_LOW_RESET;
            limit_high_reg   <= biquad_pkg::LIMIT_HIGH_RESET;
            clamp_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                biquad_pkg::REG_COEF_B0:      coef_b0_reg      <= pwdata[CW-1:0];
                biquad_pkg::REG_COEF_B1:      coef_b1_reg      <= pwdata[CW-1:0];
                biquad_pkg::REG_COEF_B2:      coef_b2_reg      <= pwdata[CW-1:0];
                biquad_pkg::REG_COEF_A1:      coef_a1_reg      <= pwdata[CW-1:0];
                biquad_pkg::REG_COEF_A2:      coef_a2_reg      <= pwdata[CW-1:0];
                biquad_pkg::REG_LIMIT_LOW:    limit_low_reg    <= pwdata[LW-1:0];
                biquad_pkg::REG_LIMIT_HIGH:   limit_high_reg   <= pwdata[LW-1:0];
                biquad_pkg::REG_CLAMP_ENABLE: clamp_enable_reg <= pwdata[0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            biquad_pkg::REG_COEF_B0:      prdata = {{(DW-CW){1'b0}}, coef_b0_reg};
            biquad_pkg::REG_COEF_B1:      prdata = {{(DW-CW){1'b0}}, coef_b1_reg};
            biquad_pkg::REG_COEF_B2:      prdata = {{(DW-CW){1'b0}}, coef_b2_reg};
            biquad_pkg::REG_COEF_A1:      prdata = {{(DW-CW){1'b0}}, coef_a1_reg};
            biquad_pkg::REG_COEF_A2:      prdata = {{(DW-CW){1'b0}}, coef_a2_reg};
            biquad_pkg::REG_LIMIT_LOW:    prdata = {{(DW-LW){1'b0}}, limit_low_reg};
            biquad_pkg::REG_LIMIT_HIGH:   prdata = {{(DW-LW){1'b0}}, limit_high_reg};
            biquad_pkg::REG_CLAMP_ENABLE: prdata = {{(DW-1){1'b0}}, clamp_enable_reg};
            default:                      prdata = '0;
        endcase
    end

    // input register and handshake
    logic                 s1_valid_reg;
    biquad_pkg::in_item_t s1_data_reg;
    logic                 out_valid_reg;
    biquad_pkg::out_item_t out_data_reg, out_data_next;
    logic                 in_take, s1_move;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
    end

    // history
    logic signed [HW-1:0] x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [HW-1:0] x0_ext, y_sat, y_fin;

    // datapath
    logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [AW-1:0] acc, acc_rnd, y_full;
    logic signed [HW-1:0] lim_lo_ext, lim_hi_ext;
    logic                 sat_hit, clamp_hit;

    assign x0_ext = HW'(s1_data_reg.sample_in);
    assign p_b0   = PW'(coef_b0_reg) * PW'(x0_ext);
    assign p_b1   = PW'(coef_b1_reg) * PW'(x1_reg);
    assign p_b2   = PW'(coef_b2_reg) * PW'(x2_reg);
    assign p_a1   = PW'(coef_a1_reg) * PW'(y1_reg);
    assign p_a2   = PW'(coef_a2_reg) * PW'(y2_reg);

    assign acc     = AW'(p_b0) + AW'(p_b1) + AW'(p_b2) - AW'(p_a1) - AW'(p_a2);
    assign acc_rnd = acc + ROUND_BIAS;
    assign y_full  = acc_rnd >>> FB;

    assign lim_lo_ext = HW'(limit_low_reg);
    assign lim_hi_ext = HW'(limit_high_reg);

    always_comb
    begin
        sat_hit   = 1'b0;
        clamp_hit = 1'b0;
        if (y_full > SAT_MAX)
        begin
            y_sat   = SAT_MAX[HW-1:0];
            sat_hit = 1'b1;
        end
        else if (y_full < SAT_MIN)
        begin
            y_sat   = SAT_MIN[HW-1:0];
            sat_hit = 1'b1;
        end
        else
        begin
            y_sat = y_full[HW-1:0];
        end

        y_fin = y_sat;
        if (clamp_enable_reg)
        begin
            if (y_sat > lim_hi_ext)
            begin
                y_fin     = lim_hi_ext;
                clamp_hit = 1'b1;
            end
            else if (y_sat < lim_lo_ext)
            begin
                y_fin     = lim_lo_ext;
                clamp_hit = 1'b1;
            end
        end

        if (s1_data_reg.req_type == biquad_pkg::REQ_CLEAR)
        begin
            out_data_next.sample_out = '0;
            out_data_next.limited    = 1'b0;
        end
        else
        begin
            out_data_next.sample_out = y_fin[SW-1:0];
            out_data_next.limited    = sat_hit || clamp_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (s1_move)
        begin
            if (s1_data_reg.req_type == biquad_pkg::REQ_CLEAR)
            begin
                x1_reg <= '0;
                x2_reg <= '0;
                y1_reg <= '0;
                y2_reg <= '0;
            end
            else
            begin
                x1_reg <= x0_ext;
                x2_reg <= x1_reg;
                y1_reg <= y_fin;
                y2_reg <= y1_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BIQ_ASSERT_NEXT(a_clear_zeroes_history,
        s1_move && s1_data_reg.req_type == biquad_pkg::REQ_CLEAR,
        x1_reg == '0 && x2_reg == '0 && y1_reg == '0 && y2_reg == '0)
    `BIQ_ASSERT_NEXT(a_sample_enters_history,
        s1_move && s1_data_reg.req_type == biquad_pkg::REQ_FILTER,
        x1_reg == $past(x0_ext) && x2_reg == $past(x1_reg) && y2_reg == $past(y1_reg))
    `BIQ_ASSERT_NOW(a_result_from_input_stage,
        $rose(out_valid_reg),
        $past(s1_valid_reg))

endmodule
